[rtl/core/glyph_blitter_1bpp_top_defines.svh]
// ----------------------------------------------------------------------------
// Glyph blitter assertion macros
// Concurrent assertion helpers for the glyph blitter; empty for synthesis.
// ----------------------------------------------------------------------------
`ifndef GLYPH_BLITTER_1BPP_TOP_DEFINES_SVH
`define GLYPH_BLITTER_1BPP_TOP_DEFINES_SVH

`ifndef SYNTHESIS
// Check that a property holds at every clock edge outside reset
`define GB1_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error(msg);
// Check that a condition never occurs outside reset
`define GB1_ASSERT_NEVER(label, cond, msg) \
  `GB1_ASSERT(label, !(cond), msg)
`else
`define GB1_ASSERT(label, prop, msg)
`define GB1_ASSERT_NEVER(label, cond, msg)
`endif

`endif

[rtl/core/gb1_pkg.sv]
// ----------------------------------------------------------------------------
// Glyph blitter package
// Shared constants, request and memory-op codes, and inter-module structs.
// ----------------------------------------------------------------------------
package gb1_pkg;

  // Default frame geometry
  localparam int ROW_BYTES_DEF  = 16;
  localparam int FRAME_ROWS_DEF = 32;

  // Glyph spacing after reset
  localparam logic [2:0] SPACING_RESET = 3'd1;

  // Result queue depth and outstanding-read counter width
  localparam int OUTQ_DEPTH = 4;
  localparam int RDCNT_W    = 3;

  typedef enum logic [1:0] {
    REQ_BEGIN  = 2'd0,
    REQ_HEADER = 2'd1,
    REQ_DATA   = 2'd2,
    REQ_READ   = 2'd3
  } gb1_req_e;

  typedef enum logic [1:0] {
    OP_WRITE     = 2'd0,
    OP_OR        = 2'd1,
    OP_READ      = 2'd2,
    OP_READ_ZERO = 2'd3
  } gb1_kind_e;

  // One memory operation handed from the sequencer to the RMW pipeline
  typedef struct packed {
    logic      vld;
    gb1_kind_e kind;
    logic [7:0] data;
  } gb1_op_t;

  // Sequencer status
  typedef struct packed {
    logic clr_busy;
    logic pend_busy;
  } gb1_seq_stat_t;

endpackage

[rtl/core/gb1_ifs.sv]
// ----------------------------------------------------------------------------
// Glyph blitter channel interfaces
// Valid/ready channels for request items, result items and configuration.
// ----------------------------------------------------------------------------
interface gb1_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] req_type;
  logic [7:0] pos_x;
  logic [7:0] pos_y;
  logic [5:0] line_height;
  logic [5:0] glyph_width;
  logic [5:0] glyph_height;
  logic [7:0] pixel_byte;
  logic [8:0] read_addr;

  modport source (output valid, req_type, pos_x, pos_y, line_height, glyph_width,
                  glyph_height, pixel_byte, read_addr, input ready);
  modport sink   (input valid, req_type, pos_x, pos_y, line_height, glyph_width,
                  glyph_height, pixel_byte, read_addr, output ready);
endinterface

interface gb1_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] read_data;

  modport source (output valid, read_data, input ready);
  modport sink   (input valid, read_data, output ready);
endinterface

interface gb1_cfg_if;
  logic       valid;
  logic       ready;
  logic [2:0] char_spacing;

  modport source (output valid, char_spacing, input ready);
  modport sink   (input valid, char_spacing, output ready);
endinterface

[rtl/core/glyph_blitter_1bpp_top.sv]
// ----------------------------------------------------------------------------
// 1bpp glyph blitter
// Draws bitmap-font glyphs into an internal one-bit-per-pixel frame buffer.
// ----------------------------------------------------------------------------
// After reset the block clears its frame memory one byte per cycle; in_ch.ready
// stays low until the clear is done. A data item at an unaligned cursor merges
// into two frame bytes and the frame memory has one write port, so in_ch.ready
// drops while the second byte is issued. A read result passes the sequencer op
// register and the pipeline stage register before it enters the result queue
// that drives out_ch, and up to four reads can be outstanding before the input
// stalls. char_spacing may be written whenever the block is idle.
`include "glyph_blitter_1bpp_top_defines.svh"

module glyph_blitter_1bpp_top import gb1_pkg::*; #(
  parameter int ROW_BYTES  = ROW_BYTES_DEF,
  parameter int FRAME_ROWS = FRAME_ROWS_DEF,
  localparam int FRAME_BYTES = ROW_BYTES * FRAME_ROWS,
  localparam int AW          = (FRAME_BYTES > 1) ? $clog2(FRAME_BYTES) : 1
) (
  input  logic      clk,
  input  logic      rst_n,
  gb1_in_if.sink    in_ch,
  gb1_out_if.source out_ch,
  gb1_cfg_if.sink   cfg_ch
);

  gb1_op_t       op;
  logic [AW-1:0] op_addr;
  gb1_seq_stat_t seq_stat;
  logic          res_vld;
  logic [7:0]    res_data;
  logic          q_full;
  logic          out_pop;
  logic          in_fire;

  assign out_pop = out_ch.valid && out_ch.ready;
  assign in_fire = in_ch.valid && in_ch.ready;

  // Turn items into memory operations
  gb1_seq #(
    .ROW_BYTES  (ROW_BYTES),
    .FRAME_ROWS (FRAME_ROWS)
  ) u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .cfg_ch    (cfg_ch),
    .out_pop   (out_pop),
    .op_r      (op),
    .op_addr_r (op_addr),
    .stat      (seq_stat)
  );

  // Read-modify-write the frame memory
  gb1_rmw #(
    .ROW_BYTES  (ROW_BYTES),
    .FRAME_ROWS (FRAME_ROWS)
  ) u_rmw (
    .clk      (clk),
    .rst_n    (rst_n),
    .op       (op),
    .op_addr  (op_addr),
    .res_vld  (res_vld),
    .res_data (res_data)
  );

  // Buffer read results
  gb1_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (res_vld),
    .push_data (res_data),
    .out_ch    (out_ch),
    .full      (q_full)
  );

  `GB1_ASSERT_NEVER(a_no_accept_in_clear, in_fire && seq_stat.clr_busy, "item taken in clear")
  `GB1_ASSERT_NEVER(a_no_accept_in_pend, in_fire && seq_stat.pend_busy, "item taken mid-byte")
  `GB1_ASSERT_NEVER(a_no_q_overflow, res_vld && q_full && !out_pop, "result queue overflow")
  `GB1_ASSERT(a_clear_no_result, seq_stat.clr_busy |-> !res_vld, "result during clear")

endmodule

[rtl/core/gb1_ram.sv]
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, registered read data (read-before-write).
// ----------------------------------------------------------------------------
module gb1_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 512,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Read old contents and write in the same cycle
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

endmodule

[rtl/core/gb1_seq.sv]
// ----------------------------------------------------------------------------
// Glyph blitter sequencer
// Holds cursor and glyph state, runs the clear pass after reset and turns
// each request item into zero, one or two frame memory operations.
// ----------------------------------------------------------------------------
module gb1_seq import gb1_pkg::*; #(
  parameter int ROW_BYTES  = ROW_BYTES_DEF,
  parameter int FRAME_ROWS = FRAME_ROWS_DEF,
  localparam int FRAME_BYTES = ROW_BYTES * FRAME_ROWS,
  localparam int AW          = (FRAME_BYTES > 1) ? $clog2(FRAME_BYTES) : 1
) (
  input  logic          clk,
  input  logic          rst_n,
  gb1_in_if.sink        in_ch,
  gb1_cfg_if.sink       cfg_ch,
  input  logic          out_pop,
  output gb1_op_t       op_r,
  output logic [AW-1:0] op_addr_r,
  output gb1_seq_stat_t stat
);

  logic               clr_active_r, clr_active_nxt;
  logic [AW-1:0]      clr_addr_r, clr_addr_nxt;
  logic [7:0]         cursor_r, cursor_nxt;
  logic [7:0]         top_r, top_nxt;
  logic [5:0]         lrows_r, lrows_nxt;
  logic [5:0]         gw_r, gw_nxt;
  logic [5:0]         grows_r, grows_nxt;
  logic [5:0]         row_idx_r, row_idx_nxt;
  logic [3:0]         byte_idx_r, byte_idx_nxt;
  logic [2:0]         spacing_r;
  logic               pend_vld_r, pend_vld_nxt;
  gb1_op_t            pend_op_r, pend_op_nxt;
  logic [AW-1:0]      pend_addr_r, pend_addr_nxt;
  logic [RDCNT_W-1:0] rd_cnt_r, rd_cnt_nxt;
  gb1_op_t            op_nxt;
  logic [AW-1:0]      op_addr_nxt;

  logic       in_fire;
  logic [3:0] bpr;
  logic [3:0] hdr_bpr;
  logic [5:0] top_off;
  logic [8:0] row;
  logic [6:0] colb;
  logic [6:0] colb1;
  logic       row_ok;
  logic       col_ok;
  logic       col1_ok;
  logic [15:0] addr0;
  logic [15:0] addr1;
  logic [2:0] sh;
  logic [7:0] lo_byte;
  logic [7:0] hi_byte;
  logic [3:0] byte_inc;
  logic [6:0] row_inc;

  // Stall while clearing, while the second half of a byte is pending,
  // or while every result slot is spoken for
  assign in_ch.ready  = !clr_active_r && !pend_vld_r && (rd_cnt_r < RDCNT_W'(OUTQ_DEPTH));
  assign in_fire      = in_ch.valid && in_ch.ready;
  assign cfg_ch.ready = 1'b1;

  assign stat.clr_busy  = clr_active_r;
  assign stat.pend_busy = pend_vld_r;

  // Frame position of the current glyph byte
  assign bpr     = 4'((7'(gw_r) + 7'd7) >> 3);
  assign hdr_bpr = 4'((7'(in_ch.glyph_width) + 7'd7) >> 3);
  assign top_off = (grows_r < lrows_r) ? (lrows_r - grows_r) : 6'd0;
  assign row     = 9'(top_r) + 9'(top_off) + 9'(row_idx_r);
  assign colb    = 7'(cursor_r[7:3]) + 7'(byte_idx_r);
  assign colb1   = colb + 7'd1;
  assign row_ok  = int'(row) < FRAME_ROWS;
  assign col_ok  = int'(colb) < ROW_BYTES;
  assign col1_ok = int'(colb1) < ROW_BYTES;
  assign addr0   = 16'(row) * 16'(ROW_BYTES) + 16'(colb);
  assign addr1   = addr0 + 16'd1;

  // Split the shifted byte over two frame bytes
  assign sh      = cursor_r[2:0];
  assign lo_byte = in_ch.pixel_byte << sh;
  assign hi_byte = in_ch.pixel_byte >> (4'd8 - 4'(sh));

  assign byte_inc = byte_idx_r + 4'd1;
  assign row_inc  = 7'(row_idx_r) + 7'd1;

  always_comb begin
    clr_active_nxt = clr_active_r;
    clr_addr_nxt   = clr_addr_r;
    cursor_nxt     = cursor_r;
    top_nxt        = top_r;
    lrows_nxt      = lrows_r;
    gw_nxt         = gw_r;
    grows_nxt      = grows_r;
    row_idx_nxt    = row_idx_r;
    byte_idx_nxt   = byte_idx_r;
    pend_vld_nxt   = 1'b0;
    pend_op_nxt    = pend_op_r;
    pend_addr_nxt  = pend_addr_r;
    op_nxt         = '0;
    op_addr_nxt    = op_addr_r;
    rd_cnt_nxt     = rd_cnt_r;

    if (clr_active_r) begin
      // Zero one frame byte per cycle
      op_nxt.vld  = 1'b1;
      op_nxt.kind = OP_WRITE;
      op_addr_nxt = clr_addr_r;
      if (clr_addr_r == AW'(FRAME_BYTES - 1)) begin
        clr_active_nxt = 1'b0;
      end else begin
        clr_addr_nxt = clr_addr_r + 1'b1;
      end
    end else if (pend_vld_r) begin
      // Issue the upper half of an unaligned byte
      op_nxt      = pend_op_r;
      op_addr_nxt = pend_addr_r;
    end else if (in_fire) begin
      case (gb1_req_e'(in_ch.req_type))
        REQ_BEGIN: begin
          cursor_nxt   = in_ch.pos_x;
          top_nxt      = in_ch.pos_y;
          lrows_nxt    = in_ch.line_height;
          grows_nxt    = 6'd0;
          row_idx_nxt  = 6'd0;
          byte_idx_nxt = 4'd0;
        end
        REQ_HEADER: begin
          gw_nxt       = in_ch.glyph_width;
          grows_nxt    = in_ch.glyph_height;
          row_idx_nxt  = 6'd0;
          byte_idx_nxt = 4'd0;
          // Empty glyph: advance at once
          if (in_ch.glyph_height == 6'd0 || hdr_bpr == 4'd0) begin
            cursor_nxt = cursor_r + 8'(in_ch.glyph_width) + 8'(spacing_r);
            grows_nxt  = 6'd0;
          end
        end
        REQ_DATA: begin
          if (grows_r != 6'd0) begin
            if (sh == 3'd0) begin
              op_nxt.vld  = row_ok && col_ok;
              op_nxt.kind = OP_WRITE;
              op_nxt.data = in_ch.pixel_byte;
              op_addr_nxt = addr0[AW-1:0];
            end else begin
              op_nxt.vld       = row_ok && col_ok;
              op_nxt.kind      = OP_OR;
              op_nxt.data      = lo_byte;
              op_addr_nxt      = addr0[AW-1:0];
              pend_vld_nxt     = 1'b1;
              pend_op_nxt.vld  = row_ok && col1_ok;
              pend_op_nxt.kind = OP_OR;
              pend_op_nxt.data = hi_byte;
              pend_addr_nxt    = addr1[AW-1:0];
            end
            // Advance glyph counters; close the glyph after its last byte
            if (byte_inc >= bpr) begin
              byte_idx_nxt = 4'd0;
              row_idx_nxt  = row_inc[5:0];
              if (row_inc >= 7'(grows_r)) begin
                cursor_nxt  = cursor_r + 8'(gw_r) + 8'(spacing_r);
                grows_nxt   = 6'd0;
                row_idx_nxt = 6'd0;
              end
            end else begin
              byte_idx_nxt = byte_inc;
            end
          end
        end
        REQ_READ: begin
          op_nxt.vld  = 1'b1;
          op_nxt.kind = (int'(in_ch.read_addr) < FRAME_BYTES) ? OP_READ : OP_READ_ZERO;
          op_addr_nxt = AW'(in_ch.read_addr);
        end
        default: begin
          op_nxt = '0;
        end
      endcase
    end

    // Track results owed to the output queue
    if (in_fire && gb1_req_e'(in_ch.req_type) == REQ_READ && !out_pop) begin
      rd_cnt_nxt = rd_cnt_r + 1'b1;
    end else if (out_pop && !(in_fire && gb1_req_e'(in_ch.req_type) == REQ_READ)) begin
      rd_cnt_nxt = rd_cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_active_r <= 1'b1;
      clr_addr_r   <= '0;
      cursor_r     <= '0;
      top_r        <= '0;
      lrows_r      <= '0;
      gw_r         <= '0;
      grows_r      <= '0;
      row_idx_r    <= '0;
      byte_idx_r   <= '0;
      spacing_r    <= SPACING_RESET;
      pend_vld_r   <= 1'b0;
      rd_cnt_r     <= '0;
      op_r         <= '0;
    end else begin
      clr_active_r <= clr_active_nxt;
      clr_addr_r   <= clr_addr_nxt;
      cursor_r     <= cursor_nxt;
      top_r        <= top_nxt;
      lrows_r      <= lrows_nxt;
      gw_r         <= gw_nxt;
      grows_r      <= grows_nxt;
      row_idx_r    <= row_idx_nxt;
      byte_idx_r   <= byte_idx_nxt;
      pend_vld_r   <= pend_vld_nxt;
      rd_cnt_r     <= rd_cnt_nxt;
      op_r         <= op_nxt;
      if (cfg_ch.valid) begin
        spacing_r <= cfg_ch.char_spacing;
      end
    end
    pend_op_r   <= pend_op_nxt;
    pend_addr_r <= pend_addr_nxt;
    op_addr_r   <= op_addr_nxt;
  end

endmodule

[rtl/core/gb1_rmw.sv]
// ----------------------------------------------------------------------------
// Glyph blitter read-modify-write pipeline
// Reads the frame memory, merges or overwrites, writes back, and forwards
// the previous write to a following access of the same byte.
// ----------------------------------------------------------------------------
module gb1_rmw import gb1_pkg::*; #(
  parameter int ROW_BYTES  = ROW_BYTES_DEF,
  parameter int FRAME_ROWS = FRAME_ROWS_DEF,
  localparam int FRAME_BYTES = ROW_BYTES * FRAME_ROWS,
  localparam int AW          = (FRAME_BYTES > 1) ? $clog2(FRAME_BYTES) : 1
) (
  input  logic          clk,
  input  logic          rst_n,
  input  gb1_op_t       op,
  input  logic [AW-1:0] op_addr,
  output logic          res_vld,
  output logic [7:0]    res_data
);

  gb1_op_t       s2_op_r;
  logic [AW-1:0] s2_addr_r;
  logic          last_we_r;
  logic [AW-1:0] last_addr_r;
  logic [7:0]    last_data_r;

  logic [7:0]    rdata;
  logic [7:0]    cur;
  logic          we;
  logic [7:0]    wdata;

  gb1_ram #(
    .WIDTH (8),
    .DEPTH (FRAME_BYTES)
  ) u_frame (
    .clk   (clk),
    .we    (we),
    .waddr (s2_addr_r),
    .wdata (wdata),
    .raddr (op_addr),
    .rdata (rdata)
  );

  // Take the previous cycle's write when it hit the same byte
  assign cur = (last_we_r && last_addr_r == s2_addr_r) ? last_data_r : rdata;

  // Merge and write back
  assign we    = s2_op_r.vld && (s2_op_r.kind == OP_WRITE || s2_op_r.kind == OP_OR);
  assign wdata = (s2_op_r.kind == OP_OR) ? (cur | s2_op_r.data) : s2_op_r.data;

  // Return frame bytes for reads
  assign res_vld  = s2_op_r.vld && (s2_op_r.kind == OP_READ || s2_op_r.kind == OP_READ_ZERO);
  assign res_data = (s2_op_r.kind == OP_READ_ZERO) ? 8'd0 : cur;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_op_r   <= '0;
      last_we_r <= 1'b0;
    end else begin
      s2_op_r   <= op;
      last_we_r <= we;
    end
    s2_addr_r   <= op_addr;
    last_addr_r <= s2_addr_r;
    last_data_r <= wdata;
  end

endmodule

[rtl/core/gb1_outq.sv]
// ----------------------------------------------------------------------------
// Glyph blitter result queue
// Small FIFO between the memory pipeline and the result channel.
// ----------------------------------------------------------------------------
module gb1_outq import gb1_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  input  logic [7:0] push_data,
  gb1_out_if.source  out_ch,
  output logic       full
);

  localparam int PW = $clog2(OUTQ_DEPTH);

  logic [7:0]         mem_r [OUTQ_DEPTH];
  logic [PW-1:0]      wr_ptr_r;
  logic [PW-1:0]      rd_ptr_r;
  logic [RDCNT_W-1:0] cnt_r;
  logic               pop;

  assign full             = (cnt_r == RDCNT_W'(OUTQ_DEPTH));
  assign out_ch.valid     = (cnt_r != '0);
  assign out_ch.read_data = mem_r[rd_ptr_r];
  assign pop              = out_ch.valid && out_ch.ready;

  // Hold entries until taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule
